### src/mhas_pkg.sv
// Shared types, constants and register codes for the MHAS packet framer.
package mhas_pkg;

  localparam int CONFIG_BYTES_DEFAULT = 48;

  // Request command codes.
  localparam logic CMD_CONFIG  = 1'b0;
  localparam logic CMD_PAYLOAD = 1'b1;

  // Configuration register indexes (byte address / 4).
  localparam logic [1:0] REG_WRAP       = 2'd0;
  localparam logic [1:0] REG_SYNC_EVERY = 2'd1;
  localparam logic [1:0] REG_CFG_LENGTH = 2'd2;

  // Stream constants.
  localparam logic [7:0]  SYNC_B0        = 8'hC0;
  localparam logic [7:0]  SYNC_B1        = 8'h01;
  localparam logic [7:0]  SYNC_B2        = 8'hA5;
  localparam logic [7:0]  CFG_HDR_HI     = 8'h20;
  localparam logic [4:0]  FRM_HDR_TOP    = 5'b01001;
  localparam logic [7:0]  FRM_ESC_HI     = 8'h4F;
  localparam logic [7:0]  FRM_ESC_LO     = 8'hFF;
  localparam logic [24:0] FLEN_MAX_SHORT = 25'd2046;
  localparam logic [24:0] FLEN_ESCAPE    = 25'd2047;
  localparam logic [23:0] FLEN_REM_MAX   = 24'hFFFFFF;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  byte_value;
    logic [5:0]  config_index;
    logic        frame_start;
    logic        frame_end;
    logic        random_access;
    logic [24:0] frame_length;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_end;
    logic       run_last;
  } rsp_t;

  typedef struct packed {
    logic       wrap;
    logic       sync_every;
    logic [5:0] clen;
  } cfg_t;

  // Output segments of one request, in emission order; sync is bit 0.
  typedef struct packed {
    logic pbyte;
    logic held;
    logic frm;
    logic cfg_data;
    logic cfg_hdr;
    logic sync;
  } plan_t;

  localparam plan_t PLAN_BYTE = '{pbyte: 1'b1, default: 1'b0};

  // State codes match the plan bit of each segment.
  typedef enum logic [2:0] {
    ST_SYNC     = 3'd0,
    ST_CFG_HDR  = 3'd1,
    ST_CFG_DATA = 3'd2,
    ST_FRM_HDR  = 3'd3,
    ST_HELD     = 3'd4,
    ST_BYTE     = 3'd5,
    ST_IDLE     = 3'd7
  } state_t;

  typedef struct packed {
    state_t seg;
    logic   accept;
    logic   emit;
    logic   direct;
    logic   run_last;
  } dp_cmd_t;

  typedef struct packed {
    plan_t plan_in;
    plan_t plan;
    logic  last;
    logic  out_free;
  } dp_stat_t;

endpackage

### src/mhas_packet_framer_top.sv
// Top level of the MHAS packet framer: configuration registers and block wiring.
//
// Requests arrive on src (valid/ready). A request with cmd 0 writes one byte of
// the decoder configuration store and produces nothing. A request with cmd 1
// carries one frame byte; its output bytes leave on dst (valid/ready), the last
// one of each request flagged by run_last, the last one of a frame by packet_end.
//
// Flow: a request whose only output is its own byte is taken in the cycle it
// arrives and shows on dst in the next cycle, so payload streams at one byte
// per cycle while dst keeps taking bytes. A request that opens a frame, or flushes
// the held bytes in pass mode, is accepted first and then emits its bytes in order:
// sync, config header, config bytes (up to the 48-byte default store), frame header,
// held bytes or its own byte. The sequencer emits one byte per cycle unless dst
// stalls; config bytes come from a registered-read RAM read one ahead.
// src_ready is high only while the sequencer is idle.
//
// Reset (rst, synchronous) sets wrap_raw_frames and sync_every_frame to 1,
// config_length to 0 and closes any open frame; the config store is not
// cleared and must be loaded before it is used. When dst stalls, the output
// register holds its byte and the sequencer waits; src_ready drops until the
// pending burst has gone out.
module mhas_packet_framer_top import mhas_pkg::*; #(
  parameter int CONFIG_BYTES = CONFIG_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // Request channel.
  input  logic        src_valid,
  output logic        src_ready,
  input  req_t        src_data,
  // Result channel.
  output logic        dst_valid,
  input  logic        dst_ready,
  output rsp_t        dst_data,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       wrap_raw_frames;
  logic       sync_every_frame;
  logic [5:0] config_length;
  logic       reg_write;
  cfg_t       cfg;
  dp_cmd_t    dp_cmd;
  dp_stat_t   dp_stat;

  // Registers are word aligned; the register index is the word address.
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_raw_frames  <= 1'b1;
      sync_every_frame <= 1'b1;
      config_length    <= 6'd0;
    end else if (reg_write) begin
      unique case (paddr[3:2])
        REG_WRAP:       wrap_raw_frames  <= pwdata[0];
        REG_SYNC_EVERY: sync_every_frame <= pwdata[0];
        REG_CFG_LENGTH: config_length    <= pwdata[5:0];
        default: begin
          // Writes past the last register are dropped.
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WRAP:       prdata = {31'd0, wrap_raw_frames};
      REG_SYNC_EVERY: prdata = {31'd0, sync_every_frame};
      REG_CFG_LENGTH: prdata = {26'd0, config_length};
      default:        prdata = 32'd0;
    endcase
  end

  // A length beyond the store size is clamped to the store size.
  assign cfg.wrap       = wrap_raw_frames;
  assign cfg.sync_every = sync_every_frame;
  assign cfg.clen       = (int'(config_length) > CONFIG_BYTES) ? 6'(CONFIG_BYTES)
                                                                : config_length;

  mhas_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  mhas_dp #(
    .CONFIG_BYTES (CONFIG_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .src_data  (src_data),
    .dst_ready (dst_ready),
    .dst_valid (dst_valid),
    .dst_data  (dst_data),
    .cmd       (dp_cmd),
    .stat      (dp_stat)
  );

endmodule

### src/mhas_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mhas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/mhas_dp.sv
// Datapath of the MHAS framer: framing state, config store, byte selection and output register.
module mhas_dp import mhas_pkg::*; #(
  parameter int CONFIG_BYTES = CONFIG_BYTES_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  req_t     src_data,
  input  logic     dst_ready,
  output logic     dst_valid,
  output rsp_t     dst_data,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat
);

  localparam int AW = $clog2(CONFIG_BYTES);

  // Framing state.
  logic [7:0]  held [3];
  logic [1:0]  held_count;
  logic        frame_ap;
  logic        inside_frame;

  // Latched request.
  plan_t       plan;
  logic [7:0]  pay_byte;
  logic        pay_end;
  logic [1:0]  held_n;
  logic        flen_long;
  logic [10:0] flen_lo;
  logic [23:0] flen_rem;
  logic [5:0]  cnt;

  // Next values computed from the request on the input.
  plan_t       plan_in;
  logic [7:0]  held_next [3];
  logic [1:0]  held_count_next;
  logic        frame_ap_next;
  logic        inside_frame_next;
  logic [1:0]  held_n_in;
  logic        live;
  logic        ap_eff;
  logic [1:0]  hc_eff;
  logic [1:0]  hc_inc;
  logic        is_sync;
  logic [24:0] flen_diff;

  logic        last;
  logic [7:0]  sel_byte;
  logic        sel_end;
  logic        ram_we;
  logic        ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]  ram_rdata;

  always_comb begin
    plan_in           = '0;
    held_next         = held;
    held_count_next   = held_count;
    frame_ap_next     = frame_ap;
    inside_frame_next = inside_frame;
    held_n_in         = 2'd0;
    live    = (src_data.cmd == CMD_PAYLOAD) && (src_data.frame_start || inside_frame);
    ap_eff  = src_data.frame_start ? src_data.random_access : frame_ap;
    hc_eff  = src_data.frame_start ? 2'd0 : held_count;
    hc_inc  = hc_eff + 2'd1;
    is_sync = (hc_eff == 2'd2) && (held[0] == SYNC_B0) && (held[1] == SYNC_B1)
              && (src_data.byte_value == SYNC_B2);
    if (live) begin
      frame_ap_next     = ap_eff;
      inside_frame_next = !src_data.frame_end;
      if (cfg.wrap) begin
        plan_in.sync     = src_data.frame_start && (cfg.sync_every || src_data.random_access);
        plan_in.cfg_hdr  = src_data.frame_start && src_data.random_access;
        plan_in.cfg_data = src_data.frame_start && src_data.random_access
                           && (cfg.clen != 6'd0);
        plan_in.frm      = src_data.frame_start;
        plan_in.pbyte    = 1'b1;
        held_count_next  = 2'd3;
      end else if (hc_eff != 2'd3) begin
        held_next[hc_eff] = src_data.byte_value;
        if ((hc_inc == 2'd3) || src_data.frame_end) begin
          plan_in.held    = 1'b1;
          plan_in.sync    = (cfg.sync_every || ap_eff) && !is_sync;
          held_n_in       = hc_inc;
          held_count_next = 2'd3;
        end else begin
          held_count_next = hc_inc;
        end
      end else begin
        plan_in.pbyte = 1'b1;
      end
    end
  end

  assign flen_diff = src_data.frame_length - FLEN_ESCAPE;

  always_ff @(posedge clk) begin
    if (rst) begin
      held         <= '{default: 8'h00};
      held_count   <= 2'd0;
      frame_ap     <= 1'b0;
      inside_frame <= 1'b0;
      plan         <= '0;
      cnt          <= 6'd0;
    end else if (cmd.accept) begin
      held         <= held_next;
      held_count   <= held_count_next;
      frame_ap     <= frame_ap_next;
      inside_frame <= inside_frame_next;
      plan         <= plan_in;
      cnt          <= 6'd0;
    end else if (cmd.emit) begin
      cnt <= last ? 6'd0 : cnt + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pay_byte  <= src_data.byte_value;
      pay_end   <= src_data.frame_end;
      held_n    <= held_n_in;
      flen_long <= src_data.frame_length > FLEN_MAX_SHORT;
      flen_lo   <= src_data.frame_length[10:0];
      flen_rem  <= flen_diff[24] ? FLEN_REM_MAX : flen_diff[23:0];
    end
  end

  // Config store: loaded by configuration requests, read ahead one byte while emitting.
  assign ram_we = cmd.accept && (src_data.cmd == CMD_CONFIG)
                  && (int'(src_data.config_index) < CONFIG_BYTES);
  assign ram_re = cmd.emit && (((cmd.seg == ST_CFG_HDR) && (cnt == 6'd1) && plan.cfg_data)
                  || ((cmd.seg == ST_CFG_DATA) && !last));
  assign ram_raddr = (cmd.seg == ST_CFG_HDR) ? '0 : AW'(cnt + 6'd1);

  mhas_ram #(
    .WIDTH (8),
    .DEPTH (CONFIG_BYTES)
  ) u_cfg_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (src_data.config_index[AW-1:0]),
    .wdata (src_data.byte_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    last     = 1'b0;
    sel_byte = 8'h00;
    sel_end  = 1'b0;
    unique case (cmd.seg)
      ST_SYNC: begin
        last     = (cnt == 6'd2);
        sel_byte = (cnt == 6'd0) ? SYNC_B0 : ((cnt == 6'd1) ? SYNC_B1 : SYNC_B2);
      end
      ST_CFG_HDR: begin
        last     = (cnt == 6'd1);
        sel_byte = (cnt == 6'd0) ? CFG_HDR_HI : {2'b00, cfg.clen};
      end
      ST_CFG_DATA: begin
        last     = (cnt == cfg.clen - 6'd1);
        sel_byte = ram_rdata;
      end
      ST_FRM_HDR: begin
        if (flen_long) begin
          last = (cnt == 6'd4);
          unique case (cnt[2:0])
            3'd0:    sel_byte = FRM_ESC_HI;
            3'd1:    sel_byte = FRM_ESC_LO;
            3'd2:    sel_byte = flen_rem[23:16];
            3'd3:    sel_byte = flen_rem[15:8];
            default: sel_byte = flen_rem[7:0];
          endcase
        end else begin
          last     = (cnt == 6'd1);
          sel_byte = (cnt == 6'd0) ? {FRM_HDR_TOP, flen_lo[10:8]} : flen_lo[7:0];
        end
      end
      ST_HELD: begin
        last     = (cnt == {4'b0000, held_n - 2'd1});
        sel_byte = held[cnt[1:0]];
        sel_end  = last && pay_end;
      end
      ST_BYTE: begin
        last     = 1'b1;
        sel_byte = pay_byte;
        sel_end  = pay_end;
      end
      default: begin
        last = 1'b0;
      end
    endcase
  end

  // Output register: decouples the receiver from the sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (cmd.emit || cmd.direct) begin
      dst_valid <= 1'b1;
    end else if (dst_ready) begin
      dst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.direct) begin
      dst_data <= '{out_byte: src_data.byte_value, packet_end: src_data.frame_end,
                    run_last: 1'b1};
    end else if (cmd.emit) begin
      dst_data <= '{out_byte: sel_byte, packet_end: sel_end, run_last: cmd.run_last};
    end
  end

  assign stat.plan_in  = plan_in;
  assign stat.plan     = plan;
  assign stat.last     = last;
  assign stat.out_free = !dst_valid || dst_ready;

`ifndef SYNTHESIS
  a_cfg_read_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && (cmd.seg == ST_CFG_DATA)) |-> (cnt < cfg.clen))
    else $error("config byte emitted beyond the configured length");

  a_held_nonempty: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && (cmd.seg == ST_HELD)) |-> ((held_n != 2'd0) && (cnt < {4'b0000, held_n})))
    else $error("held byte emitted with nothing held");
`endif

endmodule

### src/mhas_ctrl.sv
// Controller of the MHAS framer: walks the output segments planned for each request.
module mhas_ctrl import mhas_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     src_valid,
  output logic     src_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t st;
  state_t st_next;
  state_t follow;
  logic   direct_ok;

  // First planned segment after segment s (or ST_IDLE when none remains).
  function automatic state_t next_after(state_t s, plan_t p);
    logic [5:0] pv;
    state_t     r;
    pv = p;
    r  = ST_IDLE;
    for (int i = 5; i >= 0; i--) begin
      if (pv[i] && ((s == ST_IDLE) || (i > int'(s)))) begin
        r = state_t'(3'(i));
      end
    end
    return r;
  endfunction

  assign follow    = next_after(st, stat.plan);
  assign direct_ok = (stat.plan_in == PLAN_BYTE) && stat.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE: begin
        if (src_valid && !direct_ok) begin
          st_next = next_after(ST_IDLE, stat.plan_in);
        end
      end
      default: begin
        if (stat.out_free && stat.last) begin
          st_next = follow;
        end
      end
    endcase
  end

  always_comb begin
    cmd       = '{seg: st, default: 1'b0};
    src_ready = 1'b0;
    unique case (st)
      ST_IDLE: begin
        src_ready  = 1'b1;
        cmd.accept = src_valid;
        cmd.direct = src_valid && direct_ok;
      end
      default: begin
        cmd.emit     = stat.out_free;
        cmd.run_last = stat.last && (follow == ST_IDLE);
      end
    endcase
  end

`ifndef SYNTHESIS
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.run_last) |=> (st == ST_IDLE))
    else $error("sequencer not idle after the last byte of a request");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.direct) |-> stat.out_free)
    else $error("output register overwritten while its byte waits");
`endif

endmodule
